/* rtl/core/ecsm_pkg.sv */
// ecsm_pkg: shared types, constants and state codes for the ec scalar multiply core
// no dependencies
`timescale 1ns / 1ps

package ecsm_pkg;

    localparam int FieldWidthDef  = 16;
    localparam int ScalarWidthDef = 16;

    localparam logic [15:0] CoeffAReset  = 16'd2;
    localparam logic [15:0] ModulusReset = 16'd17;

    // register indexes
    localparam logic CfgCoeffA  = 1'b0;
    localparam logic CfgModulus = 1'b1;

    typedef struct packed {
        logic [15:0] point_x;
        logic [15:0] point_y;
        logic [15:0] scalar;
    } ecsm_in_t;

    typedef struct packed {
        logic [15:0] result_x;
        logic [15:0] result_y;
        logic        at_infinity;
    } ecsm_out_t;

    // field unit operations
    typedef enum logic [1:0] {
        OP_MUL,
        OP_RED
    } ecsm_op_t;

    typedef struct packed {
        logic     start;
        ecsm_op_t op;
    } ecsm_fu_cmd_t;

    typedef struct packed {
        logic done;
    } ecsm_fu_sts_t;

    typedef enum logic [2:0] {
        FU_IDLE,
        FU_MUL,
        FU_RED,
        FU_DONE
    } ecsm_fu_state_t;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_RED_A,
        S_RED_X,
        S_RED_Y,
        S_BIT,
        S_DBL,
        S_ADD,
        S_D_XX,
        S_D_3,
        S_D_DEN,
        S_ADD_DEN,
        S_INV,
        S_LAM,
        S_LL,
        S_Y3,
        S_STEP,
        S_OUT
    } ecsm_state_t;

endpackage

/* rtl/core/ecsm_field_unit.sv */
// ecsm_field_unit: bit-serial modular multiply and modular reduce
// depends on ecsm_pkg
`timescale 1ns / 1ps

module ecsm_field_unit #(
    parameter int FIELD_WIDTH = ecsm_pkg::FieldWidthDef
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ecsm_pkg::ecsm_fu_cmd_t   cmd,
    input  logic [FIELD_WIDTH-1:0]   op_a,
    input  logic [FIELD_WIDTH-1:0]   op_b,
    input  logic [FIELD_WIDTH-1:0]   modulus,
    output logic [FIELD_WIDTH-1:0]   result,
    output ecsm_pkg::ecsm_fu_sts_t   sts
);
    import ecsm_pkg::*;

    localparam int W  = FIELD_WIDTH;
    localparam int CW = $clog2(W + 1);

    ecsm_fu_state_t state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]   acc_reg, acc_next;    // product / remainder work
    logic [W-1:0]   sh_reg, sh_next;      // multiplier or dividend shift
    logic [W-1:0]   r1_reg, r1_next;      // divisor
    logic [W-1:0]   t1_reg, t1_next;      // multiplicand

    // one conditional-subtract step helpers
    logic [W:0] dbl, dbl_sub, rem_sh, rem_sub;

    always_comb
    begin
        dbl      = {acc_reg, 1'b0};
        dbl_sub  = dbl - {1'b0, modulus};
        rem_sh   = {acc_reg, sh_reg[W-1]};
        rem_sub  = rem_sh - {1'b0, r1_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FU_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        r1_reg  <= r1_next;
        t1_reg  <= t1_next;
    end

    always_comb
    begin
        logic [W:0] s;
        logic [W:0] m;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        sh_next    = sh_reg;
        r1_next    = r1_reg;
        t1_next    = t1_reg;
        s          = '0;
        m          = '0;
        case (state_reg)
            FU_IDLE:
            begin
                if (cmd.start)
                begin
                    acc_next = '0;
                    cnt_next = CW'(W);
                    case (cmd.op)
                        OP_MUL:
                        begin
                            sh_next    = op_b;
                            t1_next    = op_a;
                            state_next = FU_MUL;
                        end
                        OP_RED:
                        begin
                            // reduce op_a by long division by modulus
                            sh_next    = op_a;
                            r1_next    = modulus;
                            state_next = FU_RED;
                        end
                        default: state_next = FU_IDLE;
                    endcase
                end
            end
            FU_MUL:
            begin
                // msb-first double and add, operands already reduced
                s = dbl_sub[W] ? dbl : dbl_sub;
                if (sh_reg[W-1])
                begin
                    m = s + {1'b0, t1_reg};
                    s = (m >= {1'b0, modulus}) ? m - {1'b0, modulus} : m;
                end
                acc_next = s[W-1:0];
                sh_next  = {sh_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    state_next = FU_DONE;
            end
            FU_RED:
            begin
                // restoring division of sh_reg by r1_reg, remainder in acc_reg
                if (!rem_sub[W])
                    acc_next = rem_sub[W-1:0];
                else
                    acc_next = rem_sh[W-1:0];
                sh_next  = {sh_reg[W-2:0], ~rem_sub[W]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    state_next = FU_DONE;
            end
            FU_DONE:
            begin
                state_next = FU_IDLE;
            end
            default: state_next = FU_IDLE;
        endcase
    end

    assign result   = acc_reg;
    assign sts.done = (state_reg == FU_DONE);

endmodule

/* rtl/core/ec_point_scalar_multiply_core.sv */
// ec_point_scalar_multiply_core: top level of the ec scalar multiply core
// depends on ecsm_pkg and ecsm_field_unit
`timescale 1ns / 1ps
//
// usage:
//   load curve_coeff_a (index 0) and field_modulus (index 1) through cfg_we /
//   cfg_index / cfg_data while the core is idle; reset gives a = 2, p = 17
//   an item (point_x, point_y, scalar) is taken on in_valid with in_stall low;
//   in_stall stays high while an item is in progress
//   the core runs left-to-right double-and-add over SCALAR_WIDTH scalar bits
//   in affine coordinates; every field multiply and reduction runs in the
//   field unit, and each inverse runs the extended euclid loop locally, with
//   one bit-serial division and one bit-serial quotient multiply per step
//   a group operation is up to four multiplies (three for an addition) plus
//   an inverse
//   one item at a time; the result sits in an output register with out_valid
//   high until taken, and the next item is accepted while it waits
//   an asynchronous reset clears the sequencer state and drops out_valid and in_stall
//
module ec_point_scalar_multiply_core #(
    parameter int FIELD_WIDTH  = ecsm_pkg::FieldWidthDef,
    parameter int SCALAR_WIDTH = ecsm_pkg::ScalarWidthDef
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  ecsm_pkg::ecsm_in_t in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ecsm_pkg::ecsm_out_t out_data
);
    import ecsm_pkg::*;

    localparam int W  = FIELD_WIDTH;
    localparam int KW = $clog2(SCALAR_WIDTH);

    // configuration
    logic [15:0] coeff_a_reg, modulus_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_a_reg <= CoeffAReset;
            modulus_reg <= ModulusReset;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CfgCoeffA)
                coeff_a_reg <= cfg_data;
            else
                coeff_a_reg <= coeff_a_reg;
            if (cfg_index == CfgModulus)
                modulus_reg <= cfg_data;
        end
    end

    logic [W-1:0] p;
    assign p = W'(modulus_reg);

    // sequencer registers
    ecsm_state_t  state_reg, state_next;
    logic [KW-1:0] bit_reg, bit_next;
    logic [SCALAR_WIDTH-1:0] k_reg, k_next;
    logic [W-1:0] a_reg, a_next, bx_reg, bx_next, by_reg, by_next;
    logic [W-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic         ainf_reg, ainf_next;
    logic [W-1:0] num_reg, num_next, den_reg, den_next, lam_reg, lam_next;
    logic [W-1:0] x3_reg, x3_next;
    logic [W-1:0] tx_reg, tx_next, ty_reg, ty_next;
    logic         dbl_reg, dbl_next;
    logic         busy_reg, busy_next;
    logic         ov_reg, ov_next;
    ecsm_out_t    od_reg, od_next;
    logic         fu_wait_reg, fu_wait_next;

    // euclid state (sequenced and divided here)
    logic [W-1:0] r0_reg, r0_next, r1_reg, r1_next;
    logic [W-1:0] e0_reg, e0_next, e1_reg, e1_next;   // coefficients mod p
    logic [1:0]   ph_reg, ph_next;

    ecsm_fu_cmd_t fu_cmd;
    ecsm_fu_sts_t fu_sts;
    logic [W-1:0] fu_a, fu_b, fu_res;

    // the field unit does multiplies and reductions only; euclid divisions
    // and quotient multiplies run locally below
    logic [W-1:0] fu_mod;

    ecsm_field_unit #(
        .FIELD_WIDTH (W)
    ) u_fu (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (fu_cmd),
        .op_a    (fu_a),
        .op_b    (fu_b),
        .modulus (fu_mod),
        .result  (fu_res),
        .sts     (fu_sts)
    );

    // bit-serial euclid division r0 / r1 done locally
    logic [W-1:0] dq_reg, dq_next, dr_reg, dr_next, dd_reg, dd_next;
    logic [$clog2(W+1)-1:0] dc_reg, dc_next;
    logic [W:0] dsh, dsb;
    // bit-serial q*e1 mod p (q < 2^W, e1 < p)
    logic [W-1:0] qm_reg, qm_next, qq_reg, qq_next;
    logic [W:0] qd, qds, qa, qas;

    always_comb
    begin
        dsh = {dr_reg, dd_reg[W-1]};
        dsb = dsh - {1'b0, r1_reg};
        qd  = {qm_reg, 1'b0};
        qds = (qd >= {1'b0, p}) ? qd - {1'b0, p} : qd;
        qa  = qds + {1'b0, e1_reg};
        qas = (qa >= {1'b0, p}) ? qa - {1'b0, p} : qa;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            busy_reg    <= 1'b0;
            ov_reg      <= 1'b0;
            fu_wait_reg <= 1'b0;
            ph_reg      <= '0;
            dc_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            ov_reg      <= ov_next;
            fu_wait_reg <= fu_wait_next;
            ph_reg      <= ph_next;
            dc_reg      <= dc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg  <= bit_next;
        k_reg    <= k_next;
        a_reg    <= a_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        ainf_reg <= ainf_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        lam_reg  <= lam_next;
        x3_reg   <= x3_next;
        tx_reg   <= tx_next;
        ty_reg   <= ty_next;
        dbl_reg  <= dbl_next;
        od_reg   <= od_next;
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
        e0_reg   <= e0_next;
        e1_reg   <= e1_next;
        dq_reg   <= dq_next;
        dr_reg   <= dr_next;
        dd_reg   <= dd_next;
        qm_reg   <= qm_next;
        qq_reg   <= qq_next;
    end

    // modular add/sub helpers on reduced values
    function automatic logic [W-1:0] fadd(input logic [W-1:0] u, input logic [W-1:0] v,
                                          input logic [W-1:0] m);
        logic [W:0] s;
        s = {1'b0, u} + {1'b0, v};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] fsub(input logic [W-1:0] u, input logic [W-1:0] v,
                                          input logic [W-1:0] m);
        logic [W:0] s;
        s = {1'b0, u} - {1'b0, v};
        if (s[W])
            s = s + {1'b0, m};
        return s[W-1:0];
    endfunction

    assign in_stall  = busy_reg;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_comb
    begin
        logic [W-1:0] t;
        logic [W-1:0] e;
        state_next   = state_reg;
        bit_next     = bit_reg;
        k_next       = k_reg;
        a_next       = a_reg;
        bx_next      = bx_reg;
        by_next      = by_reg;
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        ainf_next    = ainf_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        lam_next     = lam_reg;
        x3_next      = x3_reg;
        tx_next      = tx_reg;
        ty_next      = ty_reg;
        dbl_next     = dbl_reg;
        busy_next    = busy_reg;
        ov_next      = ov_reg;
        od_next      = od_reg;
        fu_wait_next = fu_wait_reg;
        r0_next      = r0_reg;
        r1_next      = r1_reg;
        e0_next      = e0_reg;
        e1_next      = e1_reg;
        ph_next      = ph_reg;
        dq_next      = dq_reg;
        dr_next      = dr_reg;
        dd_next      = dd_reg;
        dc_next      = dc_reg;
        qm_next      = qm_reg;
        qq_next      = qq_reg;
        fu_cmd       = '{start: 1'b0, op: OP_MUL};
        fu_a         = '0;
        fu_b         = '0;
        fu_mod       = p;
        t            = '0;
        e            = '0;

        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !busy_reg)
                begin
                    busy_next = 1'b1;
                    k_next    = SCALAR_WIDTH'(in_data.scalar);
                    bx_next   = W'(in_data.point_x);
                    by_next   = W'(in_data.point_y);
                    a_next    = W'(coeff_a_reg);
                    ainf_next = 1'b1;
                    ax_next   = '0;
                    ay_next   = '0;
                    bit_next  = KW'(SCALAR_WIDTH - 1);
                    if (p < W'(3))
                        state_next = S_OUT;
                    else
                        state_next = S_RED_A;
                end
            end
            S_RED_A, S_RED_X, S_RED_Y:
            begin
                // reduce a, x, y modulo p
                t = (state_reg == S_RED_A) ? a_reg : (state_reg == S_RED_X) ? bx_reg : by_reg;
                if (!fu_wait_reg)
                begin
                    fu_cmd       = '{start: 1'b1, op: OP_RED};
                    fu_a         = t;
                    fu_wait_next = 1'b1;
                end
                else if (fu_sts.done)
                begin
                    fu_wait_next = 1'b0;
                    case (state_reg)
                        S_RED_A: begin a_next  = fu_res; state_next = S_RED_X; end
                        S_RED_X: begin bx_next = fu_res; state_next = S_RED_Y; end
                        default: begin by_next = fu_res; state_next = S_BIT;   end
                    endcase
                end
            end
            S_BIT:
            begin
                // doubling of acc
                dbl_next = 1'b1;
                tx_next  = ax_reg;
                ty_next  = ay_reg;
                state_next = S_DBL;
            end
            S_DBL, S_ADD:
            begin
                // special cases of acc + (tx,ty); otherwise set up the slope numerator and denominator
                if (ainf_reg)
                begin
                    if (!dbl_reg)
                    begin
                        ax_next   = tx_reg;
                        ay_next   = ty_reg;
                        ainf_next = 1'b0;
                    end
                    state_next = S_STEP;
                end
                else if (ax_reg == tx_reg)
                begin
                    if (ay_reg != ty_reg || ay_reg == '0)
                    begin
                        ainf_next  = 1'b1;
                        state_next = S_STEP;
                    end
                    else
                        state_next = S_D_XX;
                end
                else
                begin
                    num_next   = fsub(ty_reg, ay_reg, p);
                    den_next   = fsub(tx_reg, ax_reg, p);
                    state_next = S_INV;
                    ph_next    = '0;
                end
            end
            S_D_XX:
            begin
                // num = 3*x^2 + a
                if (!fu_wait_reg)
                begin
                    fu_cmd       = '{start: 1'b1, op: OP_MUL};
                    fu_a         = ax_reg;
                    fu_b         = ax_reg;
                    fu_wait_next = 1'b1;
                end
                else if (fu_sts.done)
                begin
                    fu_wait_next = 1'b0;
                    t          = fadd(fu_res, fu_res, p);
                    num_next   = fadd(fadd(t, fu_res, p), a_reg, p);
                    state_next = S_D_DEN;
                end
            end
            S_D_3:
            begin
                state_next = S_D_DEN;
            end
            S_D_DEN:
            begin
                den_next   = fadd(ay_reg, ay_reg, p);
                ph_next    = '0;
                state_next = S_INV;
            end
            S_ADD_DEN:
            begin
                state_next = S_INV;
            end
            S_INV:
            begin
                // extended euclid: r0=p, r1=den, e0=0, e1=1 (coefficients mod p)
                case (ph_reg)
                    2'd0:
                    begin
                        r0_next = p;
                        r1_next = den_reg;
                        e0_next = '0;
                        e1_next = W'(1);
                        ph_next = 2'd1;
                    end
                    2'd1:
                    begin
                        if (r1_reg == '0)
                        begin
                            if (r0_reg != W'(1))
                            begin
                                ainf_next  = 1'b1;
                                state_next = S_STEP;
                            end
                            else
                            begin
                                den_next   = e0_reg;
                                state_next = S_LAM;
                            end
                        end
                        else
                        begin
                            // start division r0 / r1
                            dd_next = r0_reg;
                            dr_next = '0;
                            dq_next = '0;
                            dc_next = ($clog2(W+1))'(W);
                            ph_next = 2'd2;
                        end
                    end
                    2'd2:
                    begin
                        // one quotient bit per cycle
                        if (dc_reg != '0)
                        begin
                            if (!dsb[W])
                                dr_next = dsb[W-1:0];
                            else
                                dr_next = dsh[W-1:0];
                            dq_next = {dq_reg[W-2:0], ~dsb[W]};
                            dd_next = {dd_reg[W-2:0], 1'b0};
                            dc_next = dc_reg - 1'b1;
                        end
                        else
                        begin
                            // q*e1 mod p, one quotient bit per cycle
                            qq_next = dq_reg;
                            qm_next = '0;
                            dc_next = ($clog2(W+1))'(W);
                            ph_next = 2'd3;
                        end
                    end
                    default:
                    begin
                        if (dc_reg != '0)
                        begin
                            qm_next = qq_reg[W-1] ? qas[W-1:0] : qds[W-1:0];
                            qq_next = {qq_reg[W-2:0], 1'b0};
                            dc_next = dc_reg - 1'b1;
                        end
                        else
                        begin
                            r0_next = r1_reg;
                            r1_next = dr_reg;
                            e = fsub(e0_reg, qm_reg, p);
                            e0_next = e1_reg;
                            e1_next = e;
                            ph_next = 2'd1;
                        end
                    end
                endcase
            end
            S_LAM:
            begin
                // lambda = num * inv
                if (!fu_wait_reg)
                begin
                    fu_cmd       = '{start: 1'b1, op: OP_MUL};
                    fu_a         = num_reg;
                    fu_b         = den_reg;
                    fu_wait_next = 1'b1;
                end
                else if (fu_sts.done)
                begin
                    fu_wait_next = 1'b0;
                    lam_next     = fu_res;
                    state_next   = S_LL;
                end
            end
            S_LL:
            begin
                // x3 = lambda^2 - x1 - x2
                if (!fu_wait_reg)
                begin
                    fu_cmd       = '{start: 1'b1, op: OP_MUL};
                    fu_a         = lam_reg;
                    fu_b         = lam_reg;
                    fu_wait_next = 1'b1;
                end
                else if (fu_sts.done)
                begin
                    fu_wait_next = 1'b0;
                    x3_next      = fsub(fsub(fu_res, ax_reg, p), tx_reg, p);
                    state_next   = S_Y3;
                end
            end
            S_Y3:
            begin
                // y3 = lambda*(x1 - x3) - y1
                if (!fu_wait_reg)
                begin
                    fu_cmd       = '{start: 1'b1, op: OP_MUL};
                    fu_a         = lam_reg;
                    fu_b         = fsub(ax_reg, x3_reg, p);
                    fu_wait_next = 1'b1;
                end
                else if (fu_sts.done)
                begin
                    fu_wait_next = 1'b0;
                    ay_next      = fsub(fu_res, ay_reg, p);
                    ax_next      = x3_reg;
                    ainf_next    = 1'b0;
                    state_next   = S_STEP;
                end
            end
            S_STEP:
            begin
                // after a doubling, add the base if the bit is set; otherwise move to the next bit or to the output
                if (dbl_reg && k_reg[bit_reg])
                begin
                    dbl_next   = 1'b0;
                    tx_next    = bx_reg;
                    ty_next    = by_reg;
                    state_next = S_ADD;
                end
                else if (bit_reg == '0)
                    state_next = S_OUT;
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = S_BIT;
                end
            end
            S_OUT:
            begin
                // wait for the output register to free up
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    od_next.at_infinity = ainf_reg;
                    od_next.result_x    = ainf_reg ? 16'd0 : 16'(ax_reg);
                    od_next.result_y    = ainf_reg ? 16'd0 : 16'(ay_reg);
                    busy_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
